>>> sv/assert_macros.svh
//------------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked implication checks with a synchronous reset disable.
//------------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define NIA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define NIA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/nia_pkg.sv
//------------------------------------------------------------------------------
// nia_pkg
// Types and constants shared by the node identifier allocator.
//------------------------------------------------------------------------------
`default_nettype none

package nia_pkg;

   localparam int CATA_BEGIN = 512;
   localparam int DATA_BEGIN = 1024;
   localparam int DATA_SLOTS = 1024;
   localparam int DATA_END   = DATA_BEGIN + DATA_SLOTS;

   localparam int ID_W   = 16;
   localparam int RES_W  = 11;
   localparam int LIM_W  = 11;
   localparam int CUR_W  = 12;
   localparam int IDX_W  = 10;
   localparam int OFS_W  = 6;
   localparam int WORD_W = 1 << OFS_W;
   localparam int ROW_W  = IDX_W - OFS_W;
   localparam int ADDR_W = ROW_W + 1;
   localparam int ROWS   = 1 << ADDR_W;
   localparam int CSR_W  = 2;

   localparam int DATA_LIMIT_RST = 1024;
   localparam int CATA_LIMIT_RST = 512;

   typedef enum logic [1:0] {
      KIND_MARK       = 2'd0,
      KIND_RELEASE    = 2'd1,
      KIND_ALLOC_DATA = 2'd2,
      KIND_ALLOC_CATA = 2'd3
   } kind_type;

   typedef enum logic [CSR_W-1:0] {
      CSR_DATA_LIMIT = 2'd0,
      CSR_CATA_LIMIT = 2'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [WORD_W-1:0] data;
   } ram_wr_type;

   typedef struct packed {
      logic             hit;
      logic [OFS_W-1:0] pos;
      logic [OFS_W-1:0] gap;
      logic [OFS_W:0]   step;
   } scan_res_type;

endpackage

`default_nettype wire

>>> sv/nia_if.sv
//------------------------------------------------------------------------------
// nia_if
// Valid/ready channels of the node identifier allocator.
//------------------------------------------------------------------------------
`default_nettype none

interface nia_req_if;
   logic                     valid;
   logic                     ready;
   logic [1:0]               kind;
   logic [nia_pkg::ID_W-1:0] node_id;

   modport source (output valid, kind, node_id, input ready);
   modport sink   (input valid, kind, node_id, output ready);
endinterface

interface nia_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [nia_pkg::RES_W-1:0] result_id;
   logic                      ok;

   modport source (output valid, result_id, ok, input ready);
   modport sink   (input valid, result_id, ok, output ready);
endinterface

interface nia_csr_if;
   logic                      valid;
   logic                      ready;
   logic [nia_pkg::CSR_W-1:0] index;
   logic [nia_pkg::LIM_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> sv/node_id_allocator.sv
//------------------------------------------------------------------------------
// node_id_allocator
// Two-pool node identifier allocator: mark, release, data and catalog
// allocation with next-fit cursors over word-wide used bitmaps.
//
//   port    dir   flow       carries
//   req_ch  sink  valid/rdy  kind, node_id
//   rsp_ch  src   valid/rdy  result_id, ok
//   csr_ch  sink  valid/rdy  index, data (search limits)
//
// Mark/release: states READ, EVAL, DONE; a rejected ID goes straight to DONE.
// Allocation: one READ/EVAL pass per 64-bit bitmap word visited, bounded by the search
// limit; the read-modify cycle of the single bitmap RAM sets the pace.
// After reset a clearing pass wipes all 32 bitmap rows; req_ch is not ready.
// A new request is taken while a result waits in the output register.
//------------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module node_id_allocator (
   input  wire                clock,
   input  wire                reset,
   nia_req_if.sink            req_ch,
   nia_rsp_if.source          rsp_ch,
   nia_csr_if.sink            csr_ch
);

   nia_pkg::state_type               state_ff, state_in;
   logic [nia_pkg::ADDR_W-1:0]       clr_cnt_ff, clr_cnt_in;
   logic [nia_pkg::LIM_W-1:0]        dlim_ff, dlim_in;
   logic [nia_pkg::LIM_W-1:0]        clim_ff, clim_in;
   logic [nia_pkg::CUR_W-1:0]        dcur_ff, dcur_in;
   logic [nia_pkg::CUR_W-1:0]        ccur_ff, ccur_in;
   logic                             rsp_valid_ff, rsp_valid_in;

   nia_pkg::kind_type                op_ff, op_in;
   logic [nia_pkg::ID_W-1:0]         nid_ff, nid_in;
   logic                             pool_ff, pool_in;
   logic [nia_pkg::LIM_W-1:0]        budget_ff, budget_in;
   logic [nia_pkg::RES_W-1:0]        res_id_ff, res_id_in;
   logic                             res_ok_ff, res_ok_in;
   logic [nia_pkg::RES_W-1:0]        rsp_id_ff, rsp_id_in;
   logic                             rsp_ok_ff, rsp_ok_in;

   nia_pkg::ram_wr_type              ram_wr;
   logic [nia_pkg::WORD_W-1:0]       rd_data;
   logic [nia_pkg::ADDR_W-1:0]       rd_addr;
   nia_pkg::scan_res_type            scan;

   logic                             is_alloc;
   logic                             wrap;
   logic [nia_pkg::CUR_W-1:0]        cur_sel;
   logic [nia_pkg::CUR_W-1:0]        cur_eff;
   logic [nia_pkg::CUR_W-1:0]        base;
   logic [nia_pkg::IDX_W-1:0]        slot;
   logic [nia_pkg::OFS_W-1:0]        offset;
   logic [nia_pkg::WORD_W-1:0]       bit_mask;
   logic [nia_pkg::CUR_W-1:0]        nid_p1;
   logic [nia_pkg::CUR_W-1:0]        hit_id;
   logic [nia_pkg::CUR_W-1:0]        cur_adv;
   logic [nia_pkg::CUR_W-1:0]        cur_upd;
   logic                             cur_we;
   logic [nia_pkg::LIM_W-1:0]        budget_left;
   logic                             req_in_data;
   logic                             req_in_cat;

   // ---------------------------------------------------------------- datapath
   always_comb begin
      is_alloc = (op_ff == nia_pkg::KIND_ALLOC_DATA) || (op_ff == nia_pkg::KIND_ALLOC_CATA);
      cur_sel  = pool_ff ? dcur_ff : ccur_ff;
      wrap     = !pool_ff && is_alloc && (ccur_ff >= nia_pkg::CUR_W'(nia_pkg::DATA_BEGIN));
      cur_eff  = wrap ? nia_pkg::CUR_W'(nia_pkg::CATA_BEGIN) : cur_sel;
      base     = pool_ff ? nia_pkg::CUR_W'(nia_pkg::DATA_BEGIN) : '0;
      slot     = is_alloc ? nia_pkg::IDX_W'(cur_eff - base)
                          : nia_pkg::IDX_W'(nid_ff - nia_pkg::ID_W'(base));
      offset   = slot[nia_pkg::OFS_W-1:0];
      rd_addr  = {pool_ff, slot[nia_pkg::IDX_W-1:nia_pkg::OFS_W]};
      bit_mask = nia_pkg::WORD_W'(1) << (is_alloc ? scan.pos : offset);
      nid_p1   = nid_ff[nia_pkg::CUR_W-1:0] + nia_pkg::CUR_W'(1);
      hit_id   = cur_eff + nia_pkg::CUR_W'(scan.gap);
      cur_adv  = cur_eff + nia_pkg::CUR_W'(scan.step);
      budget_left = budget_ff - nia_pkg::LIM_W'(scan.step);
      req_in_data = (req_ch.node_id >= nia_pkg::ID_W'(nia_pkg::DATA_BEGIN)) &&
                    (req_ch.node_id < nia_pkg::ID_W'(nia_pkg::DATA_END));
      req_in_cat  = req_ch.node_id < nia_pkg::ID_W'(nia_pkg::DATA_BEGIN);
   end

   nia_bitmap_ram u_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   nia_scan_unit u_scan (
      .word   (rd_data),
      .offset (offset),
      .budget (budget_ff),
      .res    (scan)
   );

   // ---------------------------------------------------------------- csr
   assign csr_ch.ready = 1'b1;

   always_comb begin
      dlim_in = dlim_ff;
      clim_in = clim_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            nia_pkg::CSR_DATA_LIMIT: dlim_in = csr_ch.data;
            nia_pkg::CSR_CATA_LIMIT: clim_in = csr_ch.data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      dcur_in      = dcur_ff;
      ccur_in      = ccur_ff;
      op_in        = op_ff;
      nid_in       = nid_ff;
      pool_in      = pool_ff;
      budget_in    = budget_ff;
      res_id_in    = res_id_ff;
      res_ok_in    = res_ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_id_in    = rsp_id_ff;
      rsp_ok_in    = rsp_ok_ff;
      ram_wr.en    = 1'b0;
      ram_wr.addr  = rd_addr;
      ram_wr.data  = rd_data;
      cur_upd      = cur_adv;
      cur_we       = 1'b0;
      req_ch.ready = 1'b0;

      case (state_ff)
         nia_pkg::ST_CLEAR: begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = clr_cnt_ff;
            ram_wr.data = '0;
            clr_cnt_in  = clr_cnt_ff + nia_pkg::ADDR_W'(1);
            if (clr_cnt_ff == nia_pkg::ADDR_W'(nia_pkg::ROWS - 1)) begin
               state_in = nia_pkg::ST_IDLE;
            end
         end
         nia_pkg::ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               op_in     = nia_pkg::kind_type'(req_ch.kind);
               nid_in    = req_ch.node_id;
               res_id_in = req_ch.node_id[nia_pkg::RES_W-1:0];
               res_ok_in = 1'b0;
               state_in  = nia_pkg::ST_DONE;
               case (nia_pkg::kind_type'(req_ch.kind))
                  nia_pkg::KIND_MARK: begin
                     pool_in = req_in_data;
                     if (req_in_data || req_in_cat) begin
                        state_in = nia_pkg::ST_READ;
                     end
                  end
                  nia_pkg::KIND_RELEASE: begin
                     pool_in = 1'b1;
                     if (req_in_data) begin
                        state_in = nia_pkg::ST_READ;
                     end
                  end
                  nia_pkg::KIND_ALLOC_DATA: begin
                     pool_in   = 1'b1;
                     budget_in = dlim_ff;
                     res_id_in = '0;
                     if (dlim_ff != '0 && dcur_ff < nia_pkg::CUR_W'(nia_pkg::DATA_END)) begin
                        state_in = nia_pkg::ST_READ;
                     end
                  end
                  default: begin
                     pool_in   = 1'b0;
                     budget_in = clim_ff;
                     res_id_in = '0;
                     if (clim_ff != '0) begin
                        state_in = nia_pkg::ST_READ;
                     end
                  end
               endcase
            end
         end
         nia_pkg::ST_READ: begin
            if (wrap) begin
               ccur_in = cur_eff;
            end
            state_in = nia_pkg::ST_EVAL;
         end
         nia_pkg::ST_EVAL: begin
            state_in = nia_pkg::ST_DONE;
            case (op_ff)
               nia_pkg::KIND_MARK: begin
                  ram_wr.en   = 1'b1;
                  ram_wr.data = rd_data | bit_mask;
                  res_ok_in   = 1'b1;
                  cur_upd     = nid_p1;
                  cur_we      = cur_sel < nid_p1;
               end
               nia_pkg::KIND_RELEASE: begin
                  ram_wr.en   = 1'b1;
                  ram_wr.data = rd_data & ~bit_mask;
                  res_ok_in   = 1'b1;
               end
               default: begin
                  cur_we = 1'b1;
                  if (scan.hit) begin
                     ram_wr.en   = 1'b1;
                     ram_wr.data = rd_data | bit_mask;
                     cur_upd     = hit_id + nia_pkg::CUR_W'(1);
                     res_id_in   = hit_id[nia_pkg::RES_W-1:0];
                     res_ok_in   = 1'b1;
                  end else if (budget_left == '0) begin
                     cur_upd = cur_adv;
                  end else if (pool_ff &&
                               cur_adv >= nia_pkg::CUR_W'(nia_pkg::DATA_END)) begin
                     cur_upd = nia_pkg::CUR_W'(nia_pkg::DATA_END);
                  end else begin
                     budget_in = budget_left;
                     state_in  = nia_pkg::ST_READ;
                  end
               end
            endcase
            if (cur_we) begin
               if (pool_ff) begin
                  dcur_in = cur_upd;
               end else begin
                  ccur_in = cur_upd;
               end
            end
         end
         nia_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = res_id_ff;
               rsp_ok_in    = res_ok_ff;
               state_in     = nia_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = nia_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nia_pkg::ST_CLEAR;
         clr_cnt_ff   <= '0;
         dlim_ff      <= nia_pkg::LIM_W'(nia_pkg::DATA_LIMIT_RST);
         clim_ff      <= nia_pkg::LIM_W'(nia_pkg::CATA_LIMIT_RST);
         dcur_ff      <= nia_pkg::CUR_W'(nia_pkg::DATA_BEGIN);
         ccur_ff      <= nia_pkg::CUR_W'(nia_pkg::CATA_BEGIN);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         dlim_ff      <= dlim_in;
         clim_ff      <= clim_in;
         dcur_ff      <= dcur_in;
         ccur_ff      <= ccur_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      nid_ff    <= nid_in;
      pool_ff   <= pool_in;
      budget_ff <= budget_in;
      res_id_ff <= res_id_in;
      res_ok_ff <= res_ok_in;
      rsp_id_ff <= rsp_id_in;
      rsp_ok_ff <= rsp_ok_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.result_id = rsp_id_ff;
   assign rsp_ch.ok        = rsp_ok_ff;

   // ---------------------------------------------------------------- checks
   `NIA_ASSERT_IMP(a_eval_after_read, clock, reset, state_ff == nia_pkg::ST_EVAL, $past(state_ff) == nia_pkg::ST_READ, "bitmap evaluated without a read")
   `NIA_ASSERT_IMP(a_write_states, clock, reset, ram_wr.en, state_ff == nia_pkg::ST_CLEAR || state_ff == nia_pkg::ST_EVAL, "bitmap written outside clear or evaluate")
   `NIA_ASSERT_NXT(a_result_loaded, clock, reset, state_ff == nia_pkg::ST_DONE && (!rsp_valid_ff || rsp_ch.ready), rsp_valid_ff && state_ff == nia_pkg::ST_IDLE, "result not presented")
   `NIA_ASSERT_IMP(a_dcur_range, clock, reset, state_ff != nia_pkg::ST_CLEAR, dcur_ff >= nia_pkg::CUR_W'(nia_pkg::DATA_BEGIN) && dcur_ff <= nia_pkg::CUR_W'(nia_pkg::DATA_END), "data cursor out of range")

endmodule

`default_nettype wire

>>> sv/nia_bitmap_ram.sv
//------------------------------------------------------------------------------
// nia_bitmap_ram
// Used-bitmap storage for both pools, one 64-bit word per row, registered read.
//------------------------------------------------------------------------------
`default_nettype none

module nia_bitmap_ram (
   input  wire                         clock,
   input  nia_pkg::ram_wr_type         wr,
   input  wire [nia_pkg::ADDR_W-1:0]   rd_addr,
   output logic [nia_pkg::WORD_W-1:0]  rd_data
);

   logic [nia_pkg::WORD_W-1:0] mem [nia_pkg::ROWS];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

>>> sv/nia_scan_unit.sv
//------------------------------------------------------------------------------
// nia_scan_unit
// Finds the first free slot at or above the offset in one bitmap word and
// works out how many probes the word consumes within the remaining budget.
//------------------------------------------------------------------------------
`default_nettype none

module nia_scan_unit (
   input  wire [nia_pkg::WORD_W-1:0] word,
   input  wire [nia_pkg::OFS_W-1:0]  offset,
   input  wire [nia_pkg::LIM_W-1:0]  budget,
   output nia_pkg::scan_res_type     res
);

   logic [nia_pkg::WORD_W-1:0] free_mask;
   logic                       found;
   logic [nia_pkg::OFS_W-1:0]  pos;
   logic [nia_pkg::OFS_W-1:0]  gap;
   logic [nia_pkg::OFS_W:0]    span;

   always_comb begin
      free_mask = ~word & ({nia_pkg::WORD_W{1'b1}} << offset);
      found = 1'b0;
      pos   = '0;
      for (int i = nia_pkg::WORD_W - 1; i >= 0; i--) begin
         if (free_mask[i]) begin
            found = 1'b1;
            pos   = nia_pkg::OFS_W'(i);
         end
      end
      gap  = pos - offset;
      span = found ? {1'b0, gap}
                   : ((nia_pkg::OFS_W + 1)'(nia_pkg::WORD_W) - {1'b0, offset});
      res.hit  = found && (nia_pkg::LIM_W'(gap) < budget);
      res.pos  = pos;
      res.gap  = gap;
      res.step = (budget < nia_pkg::LIM_W'(span)) ? (nia_pkg::OFS_W + 1)'(budget) : span;
   end

endmodule

`default_nettype wire

>>> test/tb_top.sv
//------------------------------------------------------------------------------
// tb_top
// Self-checking bench for node_id_allocator. A queue-fed driver offers mark,
// release and allocate transactions; each accepted transaction runs through
// a bitmap-and-cursor predictor of both ID pools, and a monitor compares
// every result with the oldest prediction. Search limits change between
// phases, with random idling on both sides, a long result back-pressure
// stretch and a full drain mid-phase.
//------------------------------------------------------------------------------
module tb_top;
   import nia_pkg::*;

   localparam int WATCHDOG_CYCLES = 5000;
   localparam int LONG_HOLD       = 400;

   typedef struct packed {
      kind_type          kind;
      logic [ID_W-1:0]   node_id;
   } request_t;

   typedef struct packed {
      logic [RES_W-1:0]  result_id;
      logic              ok;
   } grant_t;

   logic clock;
   logic reset;

   nia_req_if req_ch ();
   nia_rsp_if rsp_ch ();
   nia_csr_if csr_ch ();

   node_id_allocator DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // pool model
   logic             data_taken [DATA_SLOTS];
   logic             cata_taken [DATA_BEGIN];
   logic [CUR_W-1:0] data_next;
   logic [CUR_W-1:0] cata_next;
   logic [LIM_W-1:0] data_probes;
   logic [LIM_W-1:0] cata_probes;

   request_t pending_ops[$];
   grant_t   expected_grants[$];
   int       queued_ops     = 0;
   int       accepted_ops   = 0;
   int       failures       = 0;
   int       send_idle_pct  = 0;
   int       recv_stall_pct = 0;
   int       hold_asked     = 0;
   int       hold_taken;
   int       hold_left;

   initial clock = 1'b0;
   always #1 clock = ~clock;

   function automatic grant_t predict_grant(input kind_type kind,
                                            input logic [ID_W-1:0] nid);
      grant_t g;
      int     n;
      g.result_id = nid[RES_W-1:0];
      g.ok        = 1'b0;
      case (kind)
         KIND_MARK: begin
            if (nid >= DATA_BEGIN) begin
               if (nid < DATA_END) begin
                  data_taken[nid - DATA_BEGIN] = 1'b1;
                  if (data_next < nid + 1) data_next = CUR_W'(nid + 1);
                  g.ok = 1'b1;
               end
            end else begin
               cata_taken[nid] = 1'b1;
               if (cata_next < nid + 1) cata_next = CUR_W'(nid + 1);
               g.ok = 1'b1;
            end
         end
         KIND_RELEASE: begin
            if (nid >= DATA_BEGIN && nid < DATA_END) begin
               data_taken[nid - DATA_BEGIN] = 1'b0;
               g.ok = 1'b1;
            end
         end
         KIND_ALLOC_DATA: begin
            g.result_id = '0;
            for (n = 0; n < data_probes && !g.ok; n++) begin
               if (data_next < DATA_BEGIN) data_next = CUR_W'(DATA_BEGIN);
               if (data_next >= DATA_END) begin
                  data_next = CUR_W'(DATA_END);
               end else if (!data_taken[data_next - DATA_BEGIN]) begin
                  data_taken[data_next - DATA_BEGIN] = 1'b1;
                  g.result_id = data_next[RES_W-1:0];
                  g.ok        = 1'b1;
                  data_next   = data_next + 1'b1;
               end else begin
                  data_next = data_next + 1'b1;
               end
            end
         end
         default: begin
            g.result_id = '0;
            for (n = 0; n < cata_probes && !g.ok; n++) begin
               if (cata_next >= DATA_BEGIN) cata_next = CUR_W'(CATA_BEGIN);
               if (cata_next < DATA_BEGIN) begin
                  if (!cata_taken[cata_next]) begin
                     cata_taken[cata_next] = 1'b1;
                     g.result_id = cata_next[RES_W-1:0];
                     g.ok        = 1'b1;
                  end
                  cata_next = cata_next + 1'b1;
               end
            end
         end
      endcase
      return g;
   endfunction

   function automatic logic [ID_W-1:0] near_data_cursor(input int back);
      int id;
      id = int'(data_next) - back + int'($urandom_range(0, 7));
      if (id < DATA_BEGIN) id = DATA_BEGIN;
      if (id >= DATA_END) id = DATA_END - 1;
      return ID_W'(id);
   endfunction

   function automatic request_t random_op();
      request_t op;
      int       pick;
      int       sel;
      pick       = $urandom_range(0, 99);
      sel        = $urandom_range(0, 9);
      op.node_id = ID_W'($urandom_range(0, 65535));
      if (pick < 25) begin
         op.kind = KIND_MARK;
         if (sel < 4) op.node_id = ID_W'($urandom_range(0, DATA_BEGIN - 1));
         else if (sel < 7) op.node_id = near_data_cursor(0);
         else if (sel < 8) op.node_id = ID_W'($urandom_range(DATA_BEGIN, DATA_END - 1));
      end else if (pick < 45) begin
         op.kind = KIND_RELEASE;
         if (sel < 2) op.node_id = ID_W'($urandom_range(0, DATA_BEGIN - 1));
         else if (sel < 7) op.node_id = near_data_cursor(4);
         else if (sel < 9) op.node_id = ID_W'($urandom_range(DATA_BEGIN, DATA_END - 1));
      end else if (pick < 75) begin
         op.kind = KIND_ALLOC_DATA;
      end else begin
         op.kind = KIND_ALLOC_CATA;
      end
      return op;
   endfunction

   task automatic queue_op(input kind_type kind, input logic [ID_W-1:0] nid);
      request_t op;
      op.kind    = kind;
      op.node_id = nid;
      pending_ops.push_back(op);
      queued_ops++;
   endtask

   task automatic wait_for_quiet();
      while (accepted_ops != queued_ops || expected_grants.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_limit(input csr_index_type idx, input logic [LIM_W-1:0] value);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      if (idx == CSR_DATA_LIMIT) data_probes = value;
      else cata_probes = value;
   endtask

   task automatic run_phase(input int data_lim, input int cata_lim, input int idle_pct,
                            input int stall_pct, input int count,
                            input bit hold_mid, input bit pause_mid);
      request_t op;
      int       i;
      wait_for_quiet();
      repeat (8) @(posedge clock);
      write_limit(CSR_DATA_LIMIT, LIM_W'(data_lim));
      write_limit(CSR_CATA_LIMIT, LIM_W'(cata_lim));
      send_idle_pct  <= idle_pct;
      recv_stall_pct <= stall_pct;
      for (i = 0; i < count; i++) begin
         while (pending_ops.size() >= 4) @(posedge clock);
         if (i == count / 3) begin
            if (hold_mid) hold_asked <= hold_asked + 1;
            if (pause_mid) wait_for_quiet();
         end
         op = random_op();
         queue_op(op.kind, op.node_id);
      end
   endtask

   // request driver
   always @(posedge clock) begin : driver
      request_t op;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            expected_grants.push_back(predict_grant(kind_type'(req_ch.kind),
                                                    req_ch.node_id));
            accepted_ops++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               op = pending_ops.pop_front();
               req_ch.valid   <= 1'b1;
               req_ch.kind    <= op.kind;
               req_ch.node_id <= op.node_id;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // long back-pressure stretch on results
   always @(posedge clock) begin
      if (reset) begin
         hold_left  <= 0;
         hold_taken <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_taken != hold_asked) begin
         hold_taken <= hold_asked;
         hold_left  <= LONG_HOLD;
      end
   end

   // result monitor
   always @(posedge clock) begin : monitor
      grant_t want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_grants.size() == 0) begin
               $error("unexpected result: result_id %0d ok %0d",
                      rsp_ch.result_id, rsp_ch.ok);
               failures++;
            end else begin
               want = expected_grants.pop_front();
               if (rsp_ch.result_id !== want.result_id) begin
                  $error("result_id mismatch: expected %0d, actual %0d",
                         want.result_id, rsp_ch.result_id);
                  failures++;
               end
               if (rsp_ch.ok !== want.ok) begin
                  $error("ok mismatch: expected %0d, actual %0d", want.ok, rsp_ch.ok);
                  failures++;
               end
            end
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_CYCLES) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Test completed with failures");
      $finish;
   end

   initial begin : stimulus
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.kind    = KIND_MARK;
      req_ch.node_id = '0;
      rsp_ch.ready   = 1'b0;
      csr_ch.valid   = 1'b0;
      csr_ch.index   = CSR_DATA_LIMIT;
      csr_ch.data    = '0;
      foreach (data_taken[i]) data_taken[i] = 1'b0;
      foreach (cata_taken[i]) cata_taken[i] = 1'b0;
      data_next   = CUR_W'(DATA_BEGIN);
      cata_next   = CUR_W'(CATA_BEGIN);
      data_probes = LIM_W'(DATA_LIMIT_RST);
      cata_probes = LIM_W'(CATA_LIMIT_RST);
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: pool edges, wrap, out-of-range and catalog release
      queue_op(KIND_ALLOC_DATA, 16'h0000);
      queue_op(KIND_ALLOC_CATA, 16'hFFFF);
      queue_op(KIND_MARK, 16'd0);
      queue_op(KIND_MARK, ID_W'(DATA_BEGIN - 1));
      queue_op(KIND_ALLOC_CATA, 16'h5555);
      queue_op(KIND_MARK, ID_W'(DATA_BEGIN));
      queue_op(KIND_MARK, ID_W'(DATA_END));
      queue_op(KIND_MARK, 16'hFFFF);
      queue_op(KIND_RELEASE, 16'hFFFF);
      queue_op(KIND_RELEASE, ID_W'(DATA_END));
      queue_op(KIND_RELEASE, 16'd0);
      queue_op(KIND_RELEASE, ID_W'(DATA_BEGIN - 1));
      queue_op(KIND_RELEASE, ID_W'(DATA_BEGIN));
      queue_op(KIND_ALLOC_DATA, 16'hAAAA);
      queue_op(KIND_MARK, ID_W'(DATA_BEGIN + 6));
      queue_op(KIND_RELEASE, ID_W'(DATA_BEGIN + 6));
      queue_op(KIND_ALLOC_DATA, 16'h0000);
      queue_op(KIND_ALLOC_CATA, 16'h0000);

      run_phase(1024, 1024, 0, 0, 120, 1'b0, 1'b0);
      run_phase(1, 1, 70, 0, 120, 1'b0, 1'b1);
      run_phase(1024, 1, 0, 70, 120, 1'b0, 1'b0);
      run_phase(1, 1024, 28, 28, 120, 1'b0, 1'b0);
      run_phase($urandom_range(1, 1024), $urandom_range(1, 1024), 0, 0, 120, 1'b1, 1'b0);
      run_phase($urandom_range(1, 16), $urandom_range(1, 16), 70, 70, 100, 1'b0, 1'b0);
      run_phase($urandom_range(1, 1024), $urandom_range(1, 1024), 28, 28, 150, 1'b0, 1'b0);
      run_phase(1024, 512, 0, 0, 120, 1'b0, 1'b0);

      // data cursor driven to the end of the bitmap: it saturates there
      queue_op(KIND_MARK, ID_W'(DATA_END - 1));
      queue_op(KIND_ALLOC_DATA, 16'h0000);
      queue_op(KIND_RELEASE, ID_W'(DATA_END - 1));
      queue_op(KIND_ALLOC_DATA, 16'hFFFF);

      wait_for_quiet();
      repeat (50) @(posedge clock);
      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule

>>> filelist.f
+incdir+sv
sv/nia_pkg.sv
sv/nia_if.sv
sv/nia_bitmap_ram.sv
sv/nia_scan_unit.sv
sv/node_id_allocator.sv
test/tb_top.sv
